@@ design/gas_lamp_ignition_flicker_core_defines.svh @@
`ifndef GAS_LAMP_IGNITION_FLICKER_CORE_DEFINES_SVH
`define GAS_LAMP_IGNITION_FLICKER_CORE_DEFINES_SVH

`ifndef SYNTH

`define GLFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define GLFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GLFC_ASSERT(lbl, prop, msg)

`define GLFC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/glfc_pkg.sv @@
package glfc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WARMUP = 3'd1,
        PH_ON     = 3'd2,
        PH_OFF    = 3'd3,
        PH_STAB   = 3'd4
    } phase_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] target_power;
        logic [2:0] rand_flashes;
        logic [9:0] rand_warmup_ms;
        logic [6:0] rand_on_ms;
        logic [6:0] rand_level;
        logic [6:0] rand_decay_pct;
    } cmd_word_t;

    typedef struct packed {
        logic [6:0] brightness;
        logic       brightness_valid;
        logic       active;
    } res_word_t;

    localparam logic [6:0] TARGET_MAX    = 7'd100;
    localparam logic [2:0] FLASHES_MIN   = 3'd3;
    localparam logic [2:0] FLASHES_MAX   = 3'd6;
    localparam logic [9:0] WARMUP_MIN    = 10'd200;
    localparam logic [9:0] WARMUP_MAX    = 10'd599;
    localparam logic [6:0] ON_MIN        = 7'd20;
    localparam logic [6:0] ON_MAX        = 7'd79;
    localparam logic [6:0] LEVEL_MIN     = 7'd50;
    localparam logic [6:0] LEVEL_MAX     = 7'd100;
    localparam logic [6:0] DECAY_MIN     = 7'd60;
    localparam logic [6:0] DECAY_MAX     = 7'd79;
    localparam logic [8:0] PAUSE_INIT    = 9'd400;
    localparam logic [8:0] PAUSE_FLOOR   = 9'd20;
    localparam logic [9:0] STAB_MS       = 10'd150;
    localparam logic [6:0] START_LEVEL   = 7'd10;
    localparam logic [9:0] ELAPSED_MAX   = 10'd1023;

    // Reciprocals: floor(x/100) = (x*5243)>>19 for x < 2^15,
    // floor(x/5) = (x*205)>>10 for x <= 400.
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          SHIFT_100    = 19;
    localparam logic [7:0]  RECIP_5      = 8'd205;
    localparam int          SHIFT_5      = 10;

endpackage

@@ design/gas_lamp_ignition_flicker_core.sv @@
// Path: a word accepted on cmd passes the input register and then the result register on its way to res.
// Throughput: one word per cycle while res is not stalled; the state update is a single
// pass between the input register and the result register.
// Reset: rst_n is asynchronous and active low; it empties both registers, sets the
// sequence idle with a 400 ms pause, and no clearing pass follows.
`include "gas_lamp_ignition_flicker_core_defines.svh"

module gas_lamp_ignition_flicker_core
    import glfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    logic      s1_valid_reg;
    cmd_word_t s1_word_reg;
    logic      out_valid_reg;
    res_word_t out_word_reg;
    logic      out_load;
    logic      advance;
    res_word_t result;

    assign out_load  = !out_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && out_load;
    assign cmd_stall = s1_valid_reg && !out_load;

    glfc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (s1_word_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
                s1_valid_reg <= cmd_valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall)
            s1_word_reg <= cmd;
        if (advance)
            out_word_reg <= result;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_word_reg;

    `GLFC_ASSERT(a_no_word_lost, (s1_valid_reg && !out_load) |=> s1_valid_reg, "input word dropped while output full")
    `GLFC_ASSERT(a_level_range, (res_valid && res.brightness_valid) |-> (res.brightness <= LEVEL_MAX), "brightness above 100")
    `GLFC_ASSERT(a_quiet_is_dark, (res_valid && !res.brightness_valid) |-> (res.brightness == 7'd0), "brightness set without valid")

endmodule

@@ design/glfc_engine.sv @@
`include "gas_lamp_ignition_flicker_core_defines.svh"

module glfc_engine
    import glfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cmd_word_t word,
    output res_word_t result
);

    phase_t      phase_reg, phase_next;
    logic [6:0]  target_reg, target_next;
    logic [2:0]  flashes_reg, flashes_next;
    logic [8:0]  pause_reg, pause_next;
    logic [9:0]  step_reg, step_next;
    logic [9:0]  elapsed_reg, elapsed_next;
    logic        pend_reg, pend_next;
    logic [14:0] prod_reg, prod_next;

    logic [6:0]  target_clamped;
    logic [2:0]  flashes_clamped;
    logic [9:0]  warmup_clamped;
    logic [6:0]  on_clamped;
    logic [6:0]  level_clamped;
    logic [6:0]  decay_clamped;
    logic [9:0]  elapsed_inc;
    logic [27:0] quot_prod;
    logic [8:0]  quot;
    logic [8:0]  pause_fixed;
    logic [16:0] stab_prod;
    logic [6:0]  stab_level;

    always_comb
    begin
        if (word.target_power > {1'b0, TARGET_MAX})
            target_clamped = TARGET_MAX;
        else
            target_clamped = word.target_power[6:0];

        if (word.rand_flashes < FLASHES_MIN)
            flashes_clamped = FLASHES_MIN;
        else if (word.rand_flashes > FLASHES_MAX)
            flashes_clamped = FLASHES_MAX;
        else
            flashes_clamped = word.rand_flashes;

        if (word.rand_warmup_ms < WARMUP_MIN)
            warmup_clamped = WARMUP_MIN;
        else if (word.rand_warmup_ms > WARMUP_MAX)
            warmup_clamped = WARMUP_MAX;
        else
            warmup_clamped = word.rand_warmup_ms;

        if (word.rand_on_ms < ON_MIN)
            on_clamped = ON_MIN;
        else if (word.rand_on_ms > ON_MAX)
            on_clamped = ON_MAX;
        else
            on_clamped = word.rand_on_ms;

        if (word.rand_level < LEVEL_MIN)
            level_clamped = LEVEL_MIN;
        else if (word.rand_level > LEVEL_MAX)
            level_clamped = LEVEL_MAX;
        else
            level_clamped = word.rand_level;

        if (word.rand_decay_pct < DECAY_MIN)
            decay_clamped = DECAY_MIN;
        else if (word.rand_decay_pct > DECAY_MAX)
            decay_clamped = DECAY_MAX;
        else
            decay_clamped = word.rand_decay_pct;
    end

    // The shrunken pause passes through prod_reg and pend_reg into pause_reg once the flash-off starts;
    // it is next needed only at the end of the following flash-on.
    assign quot_prod = 28'(prod_reg) * 28'(RECIP_100);
    assign quot      = quot_prod[SHIFT_100 +: 9];
    assign pause_fixed = (quot < PAUSE_FLOOR) ? PAUSE_FLOOR : quot;

    assign stab_prod  = 17'({target_reg, 2'b00}) * 17'(RECIP_5);
    assign stab_level = stab_prod[SHIFT_5 +: 7];

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 10'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        target_next  = target_reg;
        flashes_next = flashes_reg;
        pause_next   = pend_reg ? pause_fixed : pause_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        pend_next    = 1'b0;
        prod_next    = prod_reg;
        result       = '0;

        if (advance)
        begin
            if (word.operation == OP_START)
            begin
                target_next  = target_clamped;
                flashes_next = flashes_clamped;
                pause_next   = PAUSE_INIT;
                phase_next   = PH_WARMUP;
                step_next    = warmup_clamped;
                elapsed_next = '0;
                result.brightness       = START_LEVEL;
                result.brightness_valid = 1'b1;
                result.active           = 1'b1;
            end
            else if (phase_reg inside {PH_WARMUP, PH_ON, PH_OFF, PH_STAB})
            begin
                result.active = 1'b1;
                if (elapsed_inc >= step_reg)
                begin
                    elapsed_next = '0;
                    result.brightness_valid = 1'b1;
                    case (phase_reg)
                        PH_WARMUP:
                        begin
                            phase_next = PH_ON;
                            step_next  = 10'(on_clamped);
                            result.brightness = level_clamped;
                        end
                        PH_ON:
                        begin
                            phase_next = PH_OFF;
                            step_next  = 10'(pause_reg);
                            prod_next  = 15'(pause_reg) * 15'(decay_clamped);
                            pend_next  = 1'b1;
                        end
                        PH_OFF:
                        begin
                            if (flashes_reg > 3'd1)
                            begin
                                flashes_next = flashes_reg - 3'd1;
                                phase_next   = PH_ON;
                                step_next    = 10'(on_clamped);
                                result.brightness = level_clamped;
                            end
                            else
                            begin
                                flashes_next = '0;
                                phase_next   = PH_STAB;
                                step_next    = STAB_MS;
                                result.brightness = stab_level;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            result.brightness = target_reg;
                        end
                    endcase
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            target_reg  <= '0;
            flashes_reg <= '0;
            pause_reg   <= PAUSE_INIT;
            step_reg    <= '0;
            elapsed_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            target_reg  <= target_next;
            flashes_reg <= flashes_next;
            pause_reg   <= pause_next;
            step_reg    <= step_next;
            elapsed_reg <= elapsed_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    `GLFC_ASSERT(a_pend_one_cycle, pend_reg |=> !pend_reg || $past(advance), "pause fix pending too long")
    `GLFC_ASSERT(a_elapsed_below_step, (phase_reg != PH_IDLE) |-> (elapsed_reg < step_reg), "elapsed reached step while running")
    `GLFC_ASSERT(a_flashes_range, flashes_reg <= FLASHES_MAX, "flash count out of range")
    `GLFC_ASSERT(a_off_has_flash, (phase_reg == PH_OFF) |-> (flashes_reg != 3'd0), "flash-off with no flash left")

endmodule
